>>> hw/rtl/mbrtu_pkg.sv
// Package for the Modbus RTU read-input slave.
// Holds sequencer states, CRC unit command type and protocol constants.
// No dependencies.
package mbrtu_pkg;

    // Input item kinds
    localparam logic [1:0] MODE_RX_BYTE = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_WRITE   = 2'd2;

    // Configuration register indexes
    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_SILENCE    = 1'b1;

    // CRC-16, reflected polynomial
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function and exception codes
    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FC_READ_INPUT   = 8'h04;
    localparam logic [7:0]  EXC_FLAG        = 8'h80;
    localparam logic [7:0]  EXC_FUNCTION    = 8'h01;
    localparam logic [7:0]  EXC_ADDRESS     = 8'h02;
    localparam logic [7:0]  EXC_VALUE       = 8'h03;
    localparam logic [15:0] MAX_COUNT       = 16'h007D;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_FEED,
        ST_SHIFT,
        ST_CHECK,
        ST_SEND,
        ST_SEND_SHIFT,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       shift;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

>>> hw/rtl/mbrtu_crc.sv
// Bit-serial CRC-16 unit: xor in a byte, then one shift step per cycle.
// Depends on mbrtu_pkg.
module mbrtu_crc (
    input  logic                clk,
    input  logic                rst_n,
    input  mbrtu_pkg::crc_cmd_t cmd,
    output logic [15:0]         crc
);
    import mbrtu_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Pick init, byte load or one shift step
    always_comb
    begin
        priority if (cmd.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (cmd.load)
        begin
            crc_next = crc_reg ^ {8'h00, cmd.data};
        end
        else if (cmd.shift)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> hw/rtl/modbus_rtu_read_input_slave.sv
// Modbus RTU slave top level: frame store, silence timer, sequencer, reply output.
// Depends on mbrtu_pkg and mbrtu_crc.
//
// Input channel (in_valid/in_ready) carries one item per transfer: a received
// byte, a time-base tick, or a measurement word write. The tick that ends the
// line silence starts frame processing; in_ready stays low until the last
// reply byte is registered or the frame is dropped.
// Frame processing walks the stored frame through the single CRC unit, one
// bit a cycle: each byte is read from the store (ST_RD, ST_FEED) and then
// shifted in bit by bit; the two trailer bytes are only read. Each reply byte
// is then loaded into the CRC and shifted in the same way, with waits on the
// output; the two CRC bytes follow. Frames for another slave or with a bad
// CRC end after the check with no reply; frames under 4 bytes end at once.
// Output channel (out_valid/out_ready) is one register; a stalled receiver
// holds the sequencer before the next reply byte but not new input once the
// last byte is registered.
// Reset clears counters, measurement words and config to their defaults; the
// frame store needs no clearing.
module modbus_rtu_read_input_slave #(
    parameter int FRAME_BYTES = 256,
    parameter int MAP_LIMIT   = 16,
    parameter int MEAS_WORDS  = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  word_index,
    input  logic [15:0] word_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        last_byte
);
    import mbrtu_pkg::*;

    localparam int BW  = $clog2(FRAME_BYTES);
    localparam int CW  = BW + 1;
    localparam int AW  = $clog2(MAP_LIMIT);
    localparam int MIW = (MEAS_WORDS > 1) ? $clog2(MEAS_WORDS) : 1;

    // Configuration
    logic [7:0]  slave_addr_reg;
    logic [15:0] silence_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg    <= 8'd1;
            silence_ticks_reg <= 16'd4000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SLAVE_ADDR: slave_addr_reg    <= cfg_wdata[7:0];
                REG_SILENCE:    silence_ticks_reg <= cfg_wdata;
                default:        slave_addr_reg    <= slave_addr_reg;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic        in_xfer;
    logic        out_free;
    logic        frame_end;
    logic [CW-1:0] byte_count_reg;
    logic [15:0] silence_reg;
    logic [15:0] meas_reg [MEAS_WORDS];
    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [7:0]  rd_data_reg;
    logic [CW-1:0] len_reg;
    logic [BW-1:0] idx_reg;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  tail_lo_reg, tail_hi_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  k_reg;
    logic [7:0]  total_reg;
    logic [7:0]  fc_out_reg;
    logic [7:0]  third_reg;
    logic [AW-1:0] waddr_reg;
    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic [15:0] crc;
    crc_cmd_t    crc_cmd;

    logic [CW-1:0] idx_ext;
    logic        feed_crc;
    logic        walk_last;
    logic [15:0] start_w, count_w;
    logic [16:0] span;
    logic [8:0]  wa9, wi9;
    logic [15:0] word_rd;
    logic [7:0]  send_byte;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign frame_end = in_xfer && (mode == MODE_TICK) && (silence_reg == 16'd1);
    assign idx_ext   = CW'(idx_reg);
    assign feed_crc  = (idx_ext + CW'(2)) < len_reg;
    assign walk_last = (idx_ext + CW'(1)) == len_reg;
    assign start_w   = {hdr_reg[2], hdr_reg[3]};
    assign count_w   = {hdr_reg[4], hdr_reg[5]};
    assign span      = {1'b0, start_w} + {1'b0, count_w};
    assign wa9       = 9'(waddr_reg);
    assign wi9       = 9'(word_index);
    assign word_rd   = (wa9 < 9'(MEAS_WORDS)) ? meas_reg[wa9[MIW-1:0]] : 16'h0000;

    // Select the reply data byte at position k
    always_comb
    begin
        priority if (k_reg == 8'd0)
        begin
            send_byte = slave_addr_reg;
        end
        else if (k_reg == 8'd1)
        begin
            send_byte = fc_out_reg;
        end
        else if (k_reg == 8'd2)
        begin
            send_byte = third_reg;
        end
        else
        begin
            send_byte = k_reg[0] ? word_rd[15:8] : word_rd[7:0];
        end
    end

    // Frame store, write and registered read
    always_ff @(posedge clk)
    begin
        if (in_xfer && (mode == MODE_RX_BYTE) && (byte_count_reg < CW'(FRAME_BYTES)))
        begin
            frame_mem[byte_count_reg[BW-1:0]] <= rx_byte;
        end
        rd_data_reg <= frame_mem[idx_reg];
    end

    // Byte count, silence timer and measurement words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            silence_reg    <= '0;
            for (int i = 0; i < MEAS_WORDS; i++)
            begin
                meas_reg[i] <= '0;
            end
        end
        else if (in_xfer)
        begin
            unique case (mode)
                MODE_RX_BYTE:
                begin
                    if (byte_count_reg < CW'(FRAME_BYTES))
                    begin
                        byte_count_reg <= byte_count_reg + CW'(1);
                    end
                    silence_reg <= (silence_ticks_reg == 16'd0) ? 16'd1 : silence_ticks_reg;
                end
                MODE_TICK:
                begin
                    if (silence_reg != 16'd0)
                    begin
                        silence_reg <= silence_reg - 16'd1;
                    end
                    if (frame_end)
                    begin
                        byte_count_reg <= '0;
                    end
                end
                MODE_WRITE:
                begin
                    if (wi9 < 9'(MEAS_WORDS))
                    begin
                        meas_reg[wi9[MIW-1:0]] <= word_value;
                    end
                end
                default:
                begin
                    silence_reg <= silence_reg;
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_end && (byte_count_reg >= CW'(4)))
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_FEED;
            end
            ST_FEED:
            begin
                if (feed_crc)
                begin
                    state_next = ST_SHIFT;
                end
                else if (walk_last)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_SHIFT:
            begin
                if (bit_reg == 3'd7)
                begin
                    state_next = ST_RD;
                end
            end
            ST_CHECK:
            begin
                if ((hdr_reg[0] != slave_addr_reg) || ({tail_hi_reg, tail_lo_reg} != crc))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    state_next = ST_SEND_SHIFT;
                end
            end
            ST_SEND_SHIFT:
            begin
                if (bit_reg == 3'd7)
                begin
                    state_next = (k_reg + 8'd1 == total_reg) ? ST_CRC_LO : ST_SEND;
                end
            end
            ST_CRC_LO:
            begin
                if (out_free)
                begin
                    state_next = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // CRC unit commands
    always_comb
    begin
        crc_cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                crc_cmd.init = frame_end;
            end
            ST_FEED:
            begin
                crc_cmd.load = feed_crc;
                crc_cmd.data = rd_data_reg;
            end
            ST_SHIFT, ST_SEND_SHIFT:
            begin
                crc_cmd.shift = 1'b1;
            end
            ST_CHECK:
            begin
                crc_cmd.init = 1'b1;
            end
            ST_SEND:
            begin
                crc_cmd.load = out_free;
                crc_cmd.data = send_byte;
            end
            default:
            begin
                crc_cmd = '0;
            end
        endcase
    end

    mbrtu_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .crc   (crc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk and reply bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            idx_reg     <= '0;
            bit_reg     <= '0;
            k_reg       <= '0;
            tail_lo_reg <= '0;
            tail_hi_reg <= '0;
            waddr_reg   <= '0;
            third_reg   <= '0;
            total_reg   <= '0;
            fc_out_reg  <= '0;
            for (int i = 0; i < 6; i++)
            begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (frame_end)
                    begin
                        len_reg <= byte_count_reg;
                        idx_reg <= '0;
                        for (int i = 0; i < 6; i++)
                        begin
                            hdr_reg[i] <= 8'h00;
                        end
                    end
                end
                ST_FEED:
                begin
                    if (idx_ext < CW'(6))
                    begin
                        hdr_reg[idx_reg[2:0]] <= rd_data_reg;
                    end
                    if (idx_ext + CW'(2) == len_reg)
                    begin
                        tail_lo_reg <= rd_data_reg;
                    end
                    if (walk_last)
                    begin
                        tail_hi_reg <= rd_data_reg;
                    end
                    bit_reg <= '0;
                    if (!feed_crc && !walk_last)
                    begin
                        idx_reg <= idx_reg + BW'(1);
                    end
                end
                ST_SHIFT:
                begin
                    bit_reg <= bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        idx_reg <= idx_reg + BW'(1);
                    end
                end
                ST_CHECK:
                begin
                    k_reg     <= '0;
                    waddr_reg <= start_w[AW-1:0];
                    third_reg <= 8'(count_w << 1);
                    total_reg <= 8'd3 + 8'(count_w << 1);
                    fc_out_reg <= FC_READ_INPUT;
                    if ((hdr_reg[1] != FC_READ_INPUT) && (hdr_reg[1] != FC_READ_HOLDING))
                    begin
                        fc_out_reg <= hdr_reg[1] | EXC_FLAG;
                        third_reg  <= EXC_FUNCTION;
                        total_reg  <= 8'd3;
                    end
                    else if ((count_w == 16'd0) || (count_w > MAX_COUNT))
                    begin
                        fc_out_reg <= FC_READ_INPUT | EXC_FLAG;
                        third_reg  <= EXC_VALUE;
                        total_reg  <= 8'd3;
                    end
                    else if (span > 17'(MAP_LIMIT))
                    begin
                        fc_out_reg <= FC_READ_INPUT | EXC_FLAG;
                        third_reg  <= EXC_ADDRESS;
                        total_reg  <= 8'd3;
                    end
                end
                ST_SEND:
                begin
                    bit_reg <= '0;
                end
                ST_SEND_SHIFT:
                begin
                    bit_reg <= bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        k_reg <= k_reg + 8'd1;
                        if ((k_reg >= 8'd3) && !k_reg[0])
                        begin
                            waddr_reg <= waddr_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    bit_reg <= bit_reg;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= (state_reg == ST_SEND) || (state_reg == ST_CRC_LO) ||
                             (state_reg == ST_CRC_HI);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            last_reg <= (state_reg == ST_CRC_HI);
            priority if (state_reg == ST_SEND)
            begin
                tx_byte_reg <= send_byte;
            end
            else if (state_reg == ST_CRC_LO)
            begin
                tx_byte_reg <= crc[7:0];
            end
            else
            begin
                tx_byte_reg <= crc[15:8];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(FRAME_BYTES))
        else $error("byte count beyond frame store");
    a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_FEED || state_reg == ST_SHIFT) |->
        (len_reg >= CW'(4)))
        else $error("walking a frame shorter than four bytes");
    a_shift_in_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> feed_crc)
        else $error("CRC shift on a trailer byte");
    a_send_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (k_reg < total_reg))
        else $error("reply byte index past reply length");
`endif

endmodule

>>> bench/modbus_rtu_read_input_slave_tb.sv
// Testbench for modbus_rtu_read_input_slave: request frames in, reply bytes out,
// checked against an in-bench model of the slave. Depends on mbrtu_pkg and the RTL.
module modbus_rtu_read_input_slave_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrtu_pkg::*;

    localparam int          FRAME_MAX   = 256;
    localparam int          MAP_TOP     = 16;
    localparam int          MEAS_COUNT  = 6;
    localparam int          QUIET_WAIT  = 3000;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    // Ways of closing a frame
    localparam int CRC_GOOD = 0;
    localparam int CRC_BAD  = 1;
    localparam int CRC_NONE = 2;

    // Directed row kinds
    localparam int ROW_ITEM  = 0;
    localparam int ROW_FRAME = 1;
    localparam int ROW_RAW   = 2;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } reply_byte_t;

    typedef struct {
        int          kind;
        logic [1:0]  md;
        logic [7:0]  rx;
        logic [2:0]  idx;
        logic [15:0] val;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] cnt;
        int          crc_kind;
        bit          typed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [2:0]  word_index;
    logic [15:0] word_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tx_byte;
    logic        last_byte;

    // Slave model state
    logic [7:0]  frame_mem [FRAME_MAX];
    int unsigned frame_len;
    int unsigned silence_left;
    logic [15:0] meas_words [MEAS_COUNT];
    logic [7:0]  own_addr;
    logic [15:0] silence_cfg;
    logic [15:0] reply_crc;

    reply_byte_t reply_q [$];
    logic [7:0]  frame_q [$];
    int          errors;
    int          idle_pct;
    int          stall_pct;
    row_t        rows [20];

    modbus_rtu_read_input_slave uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .word_index (word_index),
        .word_value (word_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] stored_byte(input int unsigned i);
        if (i < frame_len && i < FRAME_MAX)
            return frame_mem[i];
        return 8'h00;
    endfunction

    // Queue one reply data byte and fold it into the reply CRC
    task automatic reply_data(input logic [7:0] b);
        reply_crc = crc_step(reply_crc, b);
        reply_q.push_back('{tx: b, last: 1'b0});
    endtask

    task automatic reply_close();
        reply_q.push_back('{tx: reply_crc[7:0], last: 1'b0});
        reply_q.push_back('{tx: reply_crc[15:8], last: 1'b1});
    endtask

    task automatic reply_exception(input logic [7:0] fc, input logic [7:0] code);
        reply_crc = CRC_INIT;
        reply_data(own_addr);
        reply_data(fc | EXC_FLAG);
        reply_data(code);
        reply_close();
    endtask

    // Check the collected frame and queue the reply it calls for
    task automatic answer_frame();
        logic [15:0]  crc;
        logic [15:0]  got;
        logic [7:0]   fc;
        int unsigned  first;
        int unsigned  num;
        logic [15:0]  w;
        if (frame_len < 4 || stored_byte(0) != own_addr)
            return;
        crc = CRC_INIT;
        for (int unsigned i = 0; i + 2 < frame_len; i++)
            crc = crc_step(crc, stored_byte(i));
        got = {stored_byte(frame_len - 1), stored_byte(frame_len - 2)};
        if (got != crc)
            return;
        fc = stored_byte(1);
        if (fc != FC_READ_INPUT && fc != FC_READ_HOLDING) begin
            reply_exception(fc, EXC_FUNCTION);
            return;
        end
        first = {stored_byte(2), stored_byte(3)};
        num   = {stored_byte(4), stored_byte(5)};
        if (num == 0 || num > MAX_COUNT) begin
            reply_exception(FC_READ_INPUT, EXC_VALUE);
            return;
        end
        if (first + num > MAP_TOP) begin
            reply_exception(FC_READ_INPUT, EXC_ADDRESS);
            return;
        end
        reply_crc = CRC_INIT;
        reply_data(own_addr);
        reply_data(FC_READ_INPUT);
        reply_data(8'((num * 2) & 8'hFF));
        for (int unsigned i = 0; i < num; i++) begin
            w = (first + i < MEAS_COUNT) ? meas_words[first + i] : 16'h0000;
            reply_data(w[15:8]);
            reply_data(w[7:0]);
        end
        reply_close();
    endtask

    // Advance the slave model by one input transfer
    task automatic model_item(input logic [1:0] md, input logic [7:0] rx,
                              input logic [2:0] idx, input logic [15:0] val);
        case (md)
            MODE_RX_BYTE:
            begin
                if (frame_len < FRAME_MAX) begin
                    frame_mem[frame_len] = rx;
                    frame_len++;
                end
                silence_left = (silence_cfg == 0) ? 1 : silence_cfg;
            end
            MODE_TICK:
            begin
                if (silence_left != 0) begin
                    silence_left--;
                    if (silence_left == 0) begin
                        answer_frame();
                        frame_len = 0;
                    end
                end
            end
            MODE_WRITE:
            begin
                if (idx < MEAS_COUNT)
                    meas_words[idx] = val;
            end
            default:
            begin
            end
        endcase
    endtask

    // Present one item, wait for its transfer; a typed row expects no reply
    task automatic put_item(input logic [1:0] md, input logic [7:0] rx,
                            input logic [2:0] idx, input logic [15:0] val,
                            input bit typed_none = 1'b0);
        int keep;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= md;
        rx_byte    <= rx;
        word_index <= idx;
        word_value <= val;
        keep = reply_q.size();
        model_item(md, rx, idx, val);
        if (typed_none)
            while (reply_q.size() > keep)
                reply_q.pop_back();
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            put_item(MODE_TICK, 8'($urandom), 3'($urandom), 16'($urandom));
    endtask

    // Send frame_q, optionally with a CRC, then let the line go silent
    task automatic send_frame(input int crc_kind);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_q[i])
            crc = crc_step(crc, frame_q[i]);
        if (crc_kind == CRC_BAD)
            crc[7:0] = ~crc[7:0];
        if (crc_kind != CRC_NONE) begin
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
        end
        foreach (frame_q[i])
            put_item(MODE_RX_BYTE, frame_q[i], 3'($urandom), 16'($urandom));
        send_ticks((silence_cfg == 0) ? 1 : silence_cfg);
    endtask

    task automatic build_request(input logic [7:0] a, input logic [7:0] fc,
                                 input logic [15:0] first, input logic [15:0] num);
        frame_q = {a, fc, first[15:8], first[7:0], num[15:8], num[7:0]};
    endtask

    // Write a register once the slave has gone quiet
    task automatic write_reg(input logic idx, input logic [15:0] val);
        in_valid <= 1'b0;
        wait (reply_q.size() == 0);
        repeat (QUIET_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SLAVE_ADDR)
            own_addr = val[7:0];
        else
            silence_cfg = val;
    endtask

    // Mostly well-formed requests with random content, some noise
    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        logic [7:0]  a;
        logic [7:0]  fc;
        logic [15:0] first;
        logic [15:0] num;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                a  = ($urandom_range(9) < 8) ? own_addr : 8'($urandom);
                fc = ($urandom_range(9) < 4) ? FC_READ_INPUT :
                     ($urandom_range(9) < 6) ? FC_READ_HOLDING : 8'($urandom);
                first = ($urandom_range(9) < 7) ? 16'($urandom_range(15)) : 16'($urandom);
                num   = ($urandom_range(9) < 7) ? 16'($urandom_range(1, 16)) : 16'($urandom);
                build_request(a, fc, first, num);
                send_frame(($urandom_range(9) == 0) ? CRC_BAD : CRC_GOOD);
                sent += 9;
            end else if (pick < 82) begin
                put_item(MODE_WRITE, 8'($urandom), 3'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 90) begin
                put_item(MODE_TICK, 8'($urandom), 3'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 95) begin
                put_item(MODE_UNUSED, 8'($urandom), 3'($urandom), 16'($urandom));
                sent++;
            end else begin
                put_item(MODE_RX_BYTE, 8'($urandom), 3'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // Receiver stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each reply transfer with the oldest expected byte
    always @(posedge clk)
    begin
        reply_byte_t want;
        if (rst_n && out_valid && out_ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply byte tx_byte=%h last_byte=%b", tx_byte, last_byte);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (tx_byte !== want.tx) begin
                    $error("tx_byte expected %h actual %h", want.tx, tx_byte);
                    errors++;
                end
                if (last_byte !== want.last) begin
                    $error("last_byte expected %b actual %b", want.last, last_byte);
                    errors++;
                end
            end
        end
    end

    // Hold a generous limit on the whole run
    initial
    begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        row_t        r;
        int          phase_idle  [4];
        int          phase_stall [4];
        logic [7:0]  phase_addr  [4];
        logic [15:0] phase_sil   [4];

        phase_idle  = '{0, 65, 0, 32};
        phase_stall = '{0, 0, 65, 32};
        phase_addr  = '{8'hFF, 8'h00, 8'h5A, 8'h01};
        phase_sil   = '{16'd1, 16'd3, 16'd0, 16'd2};

        errors     = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = 1'b0;
        cfg_wdata  = 16'h0000;
        in_valid   = 1'b0;
        mode       = MODE_TICK;
        rx_byte    = 8'h00;
        word_index = 3'd0;
        word_value = 16'h0000;
        frame_len    = 0;
        silence_left = 0;
        own_addr     = 8'h01;
        silence_cfg  = 16'd4000;
        foreach (meas_words[i])
            meas_words[i] = 16'h0000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: address 1, 4000 ticks of silence, zero words
        build_request(8'h01, FC_READ_INPUT, 16'd0, 16'd2);
        send_frame(CRC_GOOD);
        write_reg(REG_SILENCE, 16'd1);

        // Directed table
        rows[0]  = '{ROW_ITEM, MODE_UNUSED, 8'hFF, 3'd7, 16'hFFFF, 0, 0, 0, 0, 1};
        rows[1]  = '{ROW_ITEM, MODE_TICK, 8'h00, 3'd0, 16'h0000, 0, 0, 0, 0, 1};
        rows[2]  = '{ROW_ITEM, MODE_WRITE, 8'h00, 3'd0, 16'hFFFF, 0, 0, 0, 0, 1};
        rows[3]  = '{ROW_ITEM, MODE_WRITE, 8'h00, 3'd5, 16'h8001, 0, 0, 0, 0, 1};
        rows[4]  = '{ROW_ITEM, MODE_WRITE, 8'h00, 3'd6, 16'h1234, 0, 0, 0, 0, 1};
        rows[5]  = '{ROW_ITEM, MODE_WRITE, 8'h00, 3'd7, 16'h5678, 0, 0, 0, 0, 1};
        rows[6]  = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd0, 16'd6, CRC_GOOD, 0};
        rows[7]  = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_HOLDING, 16'd10, 16'd6, CRC_GOOD, 0};
        rows[8]  = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd0, 16'd0, CRC_GOOD, 0};
        rows[9]  = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd0, 16'h007E, CRC_GOOD, 0};
        rows[10] = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd15, 16'd2, CRC_GOOD, 0};
        rows[11] = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_HOLDING, 16'hFFFF, MAX_COUNT, CRC_GOOD, 0};
        rows[12] = '{ROW_FRAME, 0, 0, 0, 0, 8'h00, 16'd0, 16'd1, CRC_GOOD, 0};
        rows[13] = '{ROW_FRAME, 0, 0, 0, 0, 8'hFF, 16'd0, 16'd1, CRC_GOOD, 0};
        rows[14] = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd0, 16'd1, CRC_BAD, 0};
        rows[15] = '{ROW_FRAME, 2'd1, 0, 0, 0, FC_READ_INPUT, 16'd0, 16'd1, CRC_GOOD, 0};
        rows[16] = '{ROW_RAW, 0, 0, 0, 0, 8'h01, 0, 0, CRC_NONE, 0};
        rows[17] = '{ROW_RAW, 0, 0, 0, 0, FC_READ_INPUT, 0, 0, CRC_GOOD, 0};
        rows[18] = '{ROW_FRAME, 0, 0, 0, 0, FC_READ_INPUT, 16'd4, 16'd12, CRC_GOOD, 0};
        rows[19] = '{ROW_ITEM, MODE_TICK, 8'hFF, 3'd7, 16'hFFFF, 0, 0, 0, 0, 1};

        // Walk the table; a non-zero md on a frame row means another slave address
        foreach (rows[i]) begin
            r = rows[i];
            case (r.kind)
                ROW_ITEM:
                    put_item(r.md, r.rx, r.idx, r.val, r.typed);
                ROW_FRAME:
                begin
                    build_request((r.md != 0) ? own_addr + 8'd1 : own_addr,
                                  r.fc, r.start, r.cnt);
                    send_frame(r.crc_kind);
                end
                default:
                begin
                    // short frames: three bytes, or a bare header with CRC
                    if (r.crc_kind == CRC_NONE)
                        frame_q = {own_addr, FC_READ_INPUT, 8'h00};
                    else
                        frame_q = {own_addr, r.fc};
                    send_frame(r.crc_kind);
                end
            endcase
        end

        // Overfill the frame store, then the longest silence
        frame_q = {};
        for (int i = 0; i < FRAME_MAX + 4; i++)
            frame_q.push_back(8'($urandom));
        frame_q[0] = own_addr;
        send_frame(CRC_GOOD);
        write_reg(REG_SILENCE, 16'hFFFF);
        build_request(own_addr, FC_READ_INPUT, 16'd0, MAX_COUNT[15:0] - 16'd110);
        send_frame(CRC_GOOD);

        // Random traffic under each handshake pattern
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_SLAVE_ADDR, {8'h00, phase_addr[p]});
            write_reg(REG_SILENCE, phase_sil[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            random_traffic(40);
            idle_pct = 0;
        end

        // Drain and let the slave settle
        in_valid <= 1'b0;
        wait (reply_q.size() == 0);
        repeat (QUIET_WAIT) @(posedge clk);
        if (errors == 0 && reply_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mbrtu_pkg.sv
hw/rtl/mbrtu_crc.sv
hw/rtl/modbus_rtu_read_input_slave.sv
bench/modbus_rtu_read_input_slave_tb.sv
